>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the SwiGLU dot-product block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/dds_pkg.sv
// ----------------------------------------------------------------------------
// dds_pkg
// Types, constants and elaboration-time sigmoid table functions for the
// SwiGLU dual dot-product block.
// ----------------------------------------------------------------------------
`default_nettype none

package dds_pkg;

   // Default sizes
   localparam int DATA_BITS_DEF       = 16;
   localparam int ACC_BITS_DEF        = 48;
   localparam int SIGMOID_ENTRIES_DEF = 256;

   // Fixed-point format
   localparam int FRAC_BITS = 11;
   localparam int GATE_W    = 16;   // clamped gate value, Q.11 in [-8,8)
   localparam int OFF_W     = 15;   // gate value offset into [0,32768)
   localparam int SIG_BITS  = 16;   // sigmoid, unsigned Q0.16
   localparam int SILU_W    = 16;   // SiLU value, Q.11

   localparam logic signed [GATE_W-1:0] GATE_LO = -16'sd16384;
   localparam logic signed [GATE_W-1:0] GATE_HI = 16'sd16383;
   localparam logic signed [GATE_W-1:0] GATE_OFFSET = 16'sd16384;

   localparam logic [63:0] Q62_ONE = 64'd1 << 62;

   // Controller states
   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_MAC    = 10'b00_0000_0010,
      ST_CLAMP  = 10'b00_0000_0100,
      ST_INDEX  = 10'b00_0000_1000,
      ST_LOOKUP = 10'b00_0001_0000,
      ST_SILU   = 10'b00_0010_0000,
      ST_MUL_LO = 10'b00_0100_0000,
      ST_MUL_HI = 10'b00_1000_0000,
      ST_SUM    = 10'b01_0000_0000,
      ST_EMIT   = 10'b10_0000_0000
   } dds_state_type;

   // Controller to datapath
   typedef struct packed {
      logic op_load;
      logic acc_mac;
      logic gate_clamp;
      logic tbl_index;
      logic tbl_read;
      logic silu_mul;
      logic mul_lo;
      logic mul_hi;
      logic val_sum;
      logic emit;
   } dds_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic op_last;
   } dds_status_type;

   // Restoring division, elaboration use only
   function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      int          i;
      rem = '0;
      q   = '0;
      for (i = 63; i >= 0; i--) begin
         rem = {rem[63:0], n[i]};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // (a*b) >> 62 for Q0.62 operands
   function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // Sigmoid table entry: sigmoid(-8 + 16*idx/entries) in Q0.16, rounded
   function automatic logic [SIG_BITS-1:0] sig_entry(int unsigned idx,
                                                     int unsigned entries);
      logic [63:0]        pw [16];
      logic [63:0]        term;
      logic [63:0]        sum;
      logic [63:0]        e;
      logic [63:0]        e40;
      logic [63:0]        d;
      logic [63:0]        num;
      logic [63:0]        q;
      logic [63:0]        aj;
      logic signed [63:0] j;
      int                 k;
      int                 b;
      // exp(-1/4096) by Taylor series in Q0.62
      term = Q62_ONE;
      sum  = Q62_ONE;
      for (k = 1; k <= 7; k++) begin
         term = udiv64(term >> 12, 64'(k));
         if ((k % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      pw[0] = sum;
      for (b = 1; b < 16; b++) begin
         pw[b] = mul_q62(pw[b-1], pw[b-1]);
      end
      // exp(-|j|/4096) by binary powers
      j  = $signed(udiv64(64'(idx) * 64'd65536, 64'(entries))) - 64'sd32768;
      aj = (j < 0) ? 64'(-j) : 64'(j);
      e  = Q62_ONE;
      for (b = 0; b < 16; b++) begin
         if (aj[b]) begin
            e = mul_q62(e, pw[b]);
         end
      end
      e40 = e >> 22;
      d   = (64'd1 << 40) + e40;
      if (j >= 0) begin
         num = (64'd1 << 56) + (d >> 1);
      end else begin
         num = (e40 << 16) + (d >> 1);
      end
      q = udiv64(num, d);
      return q[SIG_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

>>> hdl/dds_ctrl.sv
// ----------------------------------------------------------------------------
// dds_ctrl
// Sequencer for the SwiGLU dot-product block: input transfer, accumulate,
// and the finish sequence that turns both sums into one result.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_ctrl
   import dds_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output dds_cmd_type         cmd,
   input  wire dds_status_type status
);

   dds_state_type state_ff;
   dds_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          out_free;

   // Output register can take a new result when empty or draining
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op_load = 1'b1;
               state_in    = ST_MAC;
            end
         end
         ST_MAC: begin
            cmd.acc_mac = 1'b1;
            state_in    = status.op_last ? ST_CLAMP : ST_IDLE;
         end
         ST_CLAMP: begin
            cmd.gate_clamp = 1'b1;
            state_in       = ST_INDEX;
         end
         ST_INDEX: begin
            cmd.tbl_index = 1'b1;
            state_in      = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.tbl_read = 1'b1;
            state_in     = ST_SILU;
         end
         ST_SILU: begin
            cmd.silu_mul = 1'b1;
            state_in     = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.val_sum = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Set on emit, drop on transfer
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/dds_datapath.sv
// ----------------------------------------------------------------------------
// dds_datapath
// Operand registers, two multiply-accumulators, gate clamp, sigmoid table,
// SiLU and up-sum products, and the saturating result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_datapath
   import dds_pkg::*;
#(
   parameter int DATA_BITS       = DATA_BITS_DEF,
   parameter int ACC_BITS        = ACC_BITS_DEF,
   parameter int SIGMOID_ENTRIES = SIGMOID_ENTRIES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic signed [DATA_BITS-1:0] req_activation,
   input  wire logic signed [DATA_BITS-1:0] req_gate_coef,
   input  wire logic signed [DATA_BITS-1:0] req_up_coef,
   input  wire logic                        req_last,
   input  wire dds_cmd_type                 cmd,
   output dds_status_type                   status,
   output logic signed [DATA_BITS-1:0]      rsp_result,
   output logic                             rsp_saturated
);

   localparam int PROD_W = 2 * DATA_BITS;
   localparam int U_W    = ACC_BITS - FRAC_BITS;     // up sum in Q.11
   localparam int H_W    = U_W / 2;                  // low part of up sum
   localparam int UH_W   = U_W - H_W;                // high part of up sum
   localparam int PLO_W  = SILU_W + H_W + 1;
   localparam int PHI_W  = SILU_W + UH_W;
   localparam int VAL_W  = SILU_W + U_W;
   localparam int SH_W   = VAL_W - FRAC_BITS;
   localparam int CMP_W  = ((SH_W > DATA_BITS) ? SH_W : DATA_BITS) + 1;
   localparam int IDX_W  = (SIGMOID_ENTRIES > 1) ? $clog2(SIGMOID_ENTRIES) : 1;
   localparam int IDXR_W = $clog2(SIGMOID_ENTRIES + 1);
   localparam int IDXP_W = OFF_W + IDXR_W;

   // Sigmoid table, built at elaboration
   logic [SIG_BITS-1:0] sig_rom [SIGMOID_ENTRIES];

   for (genvar gi = 0; gi < SIGMOID_ENTRIES; gi++) begin : g_sig_rom
      localparam logic [SIG_BITS-1:0] ENTRY_VAL = sig_entry(gi, SIGMOID_ENTRIES);
      assign sig_rom[gi] = ENTRY_VAL;
   end

   logic signed [DATA_BITS-1:0] op_a_ff;
   logic signed [DATA_BITS-1:0] op_g_ff;
   logic signed [DATA_BITS-1:0] op_u_ff;
   logic                        op_last_ff;
   logic [ACC_BITS-1:0]         gate_acc_ff;
   logic [ACC_BITS-1:0]         gate_acc_in;
   logic [ACC_BITS-1:0]         up_acc_ff;
   logic [ACC_BITS-1:0]         up_acc_in;
   logic signed [GATE_W-1:0]    g_ff;
   logic signed [U_W-1:0]       u_ff;
   logic [IDX_W-1:0]            idx_ff;
   logic [SIG_BITS-1:0]         sig_ff;
   logic signed [31:0]          prod_ff;
   logic signed [PLO_W-1:0]     plo_ff;
   logic signed [PHI_W-1:0]     phi_ff;
   logic signed [VAL_W-1:0]     val_ff;
   logic signed [DATA_BITS-1:0] result_ff;
   logic                        sat_ff;

   logic signed [PROD_W-1:0]    prod_gate;
   logic signed [PROD_W-1:0]    prod_up;
   logic signed [U_W-1:0]       g_full;
   logic signed [GATE_W-1:0]    g_clamp;
   logic [GATE_W-1:0]           g_off;
   logic [IDXP_W-1:0]           idx_prod;
   logic [IDXR_W-1:0]           idx_raw;
   logic [IDX_W-1:0]            idx_in;
   logic signed [32:0]          silu_prod;
   logic signed [SILU_W-1:0]    silu;
   logic signed [PLO_W-1:0]     plo_in;
   logic signed [PHI_W-1:0]     phi_in;
   logic signed [VAL_W-1:0]     val_in;
   logic signed [SH_W-1:0]      val_sh;
   logic signed [CMP_W-1:0]     val_cmp;
   logic signed [CMP_W-1:0]     lim_hi;
   logic signed [CMP_W-1:0]     lim_lo;
   logic signed [DATA_BITS-1:0] result_in;
   logic                        sat_in;

   // Multiply-accumulate, wraps modulo the accumulator width
   assign prod_gate   = op_a_ff * op_g_ff;
   assign prod_up     = op_a_ff * op_u_ff;
   assign gate_acc_in = gate_acc_ff + ACC_BITS'(prod_gate);
   assign up_acc_in   = up_acc_ff + ACC_BITS'(prod_up);

   // Floor shift to Q.11 and clamp gate to [-8,8)
   assign g_full = $signed(gate_acc_ff[ACC_BITS-1:FRAC_BITS]);
   always_comb begin
      if (g_full < GATE_LO) begin
         g_clamp = GATE_LO;
      end else if (g_full > GATE_HI) begin
         g_clamp = GATE_HI;
      end else begin
         g_clamp = g_full[GATE_W-1:0];
      end
   end

   // Table index from the offset gate value
   assign g_off    = g_ff + GATE_OFFSET;
   assign idx_prod = IDXP_W'(g_off[OFF_W-1:0]) * IDXP_W'(SIGMOID_ENTRIES);
   assign idx_raw  = idx_prod[IDXP_W-1:OFF_W];
   always_comb begin
      if (idx_raw >= IDXR_W'(SIGMOID_ENTRIES)) begin
         idx_in = IDX_W'(SIGMOID_ENTRIES - 1);
      end else begin
         idx_in = idx_raw[IDX_W-1:0];
      end
   end

   // SiLU = gate * sigmoid >> 16, then two partial products with the up sum
   assign silu_prod = g_ff * $signed({1'b0, sig_ff});
   assign silu      = prod_ff[31:16];
   assign plo_in    = silu * $signed({1'b0, u_ff[H_W-1:0]});
   assign phi_in    = silu * $signed(u_ff[U_W-1:H_W]);
   assign val_in    = (VAL_W'(phi_ff) <<< H_W) + VAL_W'(plo_ff);

   // Floor shift to Q.11 and saturate to the result width
   assign val_sh  = val_ff[VAL_W-1:FRAC_BITS];
   assign val_cmp = CMP_W'(val_sh);
   assign lim_hi  = $signed({{(CMP_W-DATA_BITS+1){1'b0}}, {(DATA_BITS-1){1'b1}}});
   assign lim_lo  = ~lim_hi;
   always_comb begin
      if (val_cmp > lim_hi) begin
         result_in = lim_hi[DATA_BITS-1:0];
         sat_in    = 1'b1;
      end else if (val_cmp < lim_lo) begin
         result_in = lim_lo[DATA_BITS-1:0];
         sat_in    = 1'b1;
      end else begin
         result_in = val_cmp[DATA_BITS-1:0];
         sat_in    = 1'b0;
      end
   end

   // Accumulators: add on each item, clear once the sums are taken
   always_ff @(posedge clock) begin
      if (reset) begin
         gate_acc_ff <= '0;
         up_acc_ff   <= '0;
      end else if (cmd.acc_mac) begin
         gate_acc_ff <= gate_acc_in;
         up_acc_ff   <= up_acc_in;
      end else if (cmd.gate_clamp) begin
         gate_acc_ff <= '0;
         up_acc_ff   <= '0;
      end
   end

   // Payload registers, each loaded in its own step
   always_ff @(posedge clock) begin
      if (cmd.op_load) begin
         op_a_ff    <= req_activation;
         op_g_ff    <= req_gate_coef;
         op_u_ff    <= req_up_coef;
         op_last_ff <= req_last;
      end
      if (cmd.gate_clamp) begin
         g_ff <= g_clamp;
         u_ff <= $signed(up_acc_ff[ACC_BITS-1:FRAC_BITS]);
      end
      if (cmd.tbl_index) begin
         idx_ff <= idx_in;
      end
      if (cmd.tbl_read) begin
         sig_ff <= sig_rom[idx_ff];
      end
      if (cmd.silu_mul) begin
         prod_ff <= silu_prod[31:0];
      end
      if (cmd.mul_lo) begin
         plo_ff <= plo_in;
      end
      if (cmd.mul_hi) begin
         phi_ff <= phi_in;
      end
      if (cmd.val_sum) begin
         val_ff <= val_in;
      end
      if (cmd.emit) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign status.op_last = op_last_ff;
   assign rsp_result     = result_ff;
   assign rsp_saturated  = sat_ff;

endmodule

`default_nettype wire

>>> hdl/dual_dot_product_swiglu.sv
// ----------------------------------------------------------------------------
// dual_dot_product_swiglu
// Streaming SwiGLU unit: two exact dot products (gate and up) over Q4.11
// elements, then SiLU(gate) * up, saturated, on the element marked last.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_ready  activation, gate_coef, up_coef, last
//   rsp_      out        rsp_valid/rsp_ready  result, saturated
//
// An element without last passes through the transfer and one multiply-add
// into both accumulators, and no new element is taken before that is done.
// An element with last passes through the transfer, multiply-add, clamp,
// table index, table read, SiLU multiply, two partial products of SiLU and
// the up sum, sum, then saturate into the output register once it is free.
// The nine steps after the transfer, run by one controller, set the rate of
// the last element of each dot product.
// Reset (synchronous) clears both accumulators and the result valid flag.
// A result waiting on rsp_ready holds in the output register while new
// elements keep being taken; only the next emit waits for it to drain.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dual_dot_product_swiglu
   import dds_pkg::*;
#(
   parameter int DATA_BITS       = DATA_BITS_DEF,
   parameter int ACC_BITS        = ACC_BITS_DEF,
   parameter int SIGMOID_ENTRIES = SIGMOID_ENTRIES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic signed [DATA_BITS-1:0] req_activation,
   input  wire logic signed [DATA_BITS-1:0] req_gate_coef,
   input  wire logic signed [DATA_BITS-1:0] req_up_coef,
   input  wire logic                        req_last,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [DATA_BITS-1:0]      rsp_result,
   output logic                             rsp_saturated
);

   dds_cmd_type    dp_cmd;
   dds_status_type dp_status;
   logic           req_transfer;

   // Sequencer
   dds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (dp_cmd),
      .status    (dp_status)
   );

   // Arithmetic and storage
   dds_datapath #(
      .DATA_BITS       (DATA_BITS),
      .ACC_BITS        (ACC_BITS),
      .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_activation (req_activation),
      .req_gate_coef  (req_gate_coef),
      .req_up_coef    (req_up_coef),
      .req_last       (req_last),
      .cmd            (dp_cmd),
      .status         (dp_status),
      .rsp_result     (rsp_result),
      .rsp_saturated  (rsp_saturated)
   );

   assign req_transfer = req_valid && req_ready;

   // Checks on the sequencer
   `ASSERT_SAME(a_cmd_onehot, clock, reset, 1'b1, $onehot0(dp_cmd), "two datapath steps at once")
   `ASSERT_NEXT(a_transfer_mac, clock, reset, req_transfer, dp_cmd.acc_mac, "transfer not accumulated")
   `ASSERT_NEXT(a_emit_valid, clock, reset, dp_cmd.emit, rsp_valid, "emitted result not presented")
   `ASSERT_NEXT(a_emit_ready, clock, reset, dp_cmd.emit, req_ready, "input not reopened after emit")

endmodule

`default_nettype wire
